@@ design/montgomery_modular_exponentiation_macros.svh @@
// assertion macros for the montgomery exponentiation block
`ifndef MONTGOMERY_MODULAR_EXPONENTIATION_MACROS_SVH
`define MONTGOMERY_MODULAR_EXPONENTIATION_MACROS_SVH

// consequent must hold in the same cycle as the trigger
`define MME_ASSERT_IMP(label, trig, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (conseq)) \
		else $error(msg);

// consequent must hold in the cycle after the trigger
`define MME_ASSERT_NEXT(label, trig, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (conseq)) \
		else $error(msg);

`endif

@@ design/mme_pkg.sv @@
// shared constants and word types for the montgomery exponentiation block
package mme_pkg;

	localparam int OPERAND_BITS = 32;
	localparam int RBITS_W = 6;
	localparam int DATA_BITS = (OPERAND_BITS > 32) ? 64 : 32;
	localparam int ADDR_BITS = (DATA_BITS == 64) ? 4 : 3;

	// register index, taken from the top address bit
	localparam logic REG_MODULUS = 1'b0;
	localparam logic REG_R_BITS = 1'b1;

	localparam logic [OPERAND_BITS-1:0] MODULUS_RESET = OPERAND_BITS'(7);
	localparam logic [RBITS_W-1:0] R_BITS_RESET = RBITS_W'(3);

	typedef struct packed {
		logic [OPERAND_BITS-1:0] base;
		logic [OPERAND_BITS-1:0] exponent;
	} req_word_t;

	typedef struct packed {
		logic [OPERAND_BITS-1:0] result;
		logic bad_setup;
	} rsp_word_t;

endpackage

@@ design/montgomery_modular_exponentiation.sv @@
// montgomery exponentiation: bit-serial scaling, products and sequencing
// W = 32 operand bits; one word in flight; time is set by the single
// radix-2 montgomery product unit (one multiplier bit per cycle) and the
// one-bit modular doubler; a bad setup skips the scaling and products and
// goes straight to the output state; reset gives modulus 7, r_bits 3, idle
module montgomery_modular_exponentiation (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  mme_pkg::req_word_t req_data,
	output logic rsp_valid,
	input  logic rsp_ready,
	output mme_pkg::rsp_word_t rsp_data,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [mme_pkg::ADDR_BITS-1:0] paddr,
	input  logic [mme_pkg::DATA_BITS-1:0] pwdata,
	output logic [mme_pkg::DATA_BITS-1:0] prdata,
	output logic pready
);
	import mme_pkg::*;

	`include "montgomery_modular_exponentiation_macros.svh"

	localparam int W = OPERAND_BITS;
	localparam int STEP_W = $clog2(OPERAND_BITS + 64);
	localparam int EXP_W = $clog2(OPERAND_BITS + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCALE_B = 3'd1;
	localparam logic [2:0] S_SCALE_A = 3'd2;
	localparam logic [2:0] S_SQR = 3'd3;
	localparam logic [2:0] S_MUL = 3'd4;
	localparam logic [2:0] S_FIN = 3'd5;
	localparam logic [2:0] S_OUT = 3'd6;

	logic [2:0] state_q;
	logic [W-1:0] p_q;
	logic [RBITS_W-1:0] rb_q;
	logic rsp_valid_q;
	rsp_word_t rsp_data_q;

	logic [W-1:0] div_shift_q;
	logic [W-1:0] v_q;
	logic [W-1:0] base_m_q;
	logic [W-1:0] exp_q;
	logic [EXP_W-1:0] ecnt_q;
	logic [STEP_W-1:0] cnt_q;
	logic [W-1:0] ma_q;
	logic [W-1:0] mb_q;
	logic [W:0] t_q;
	logic [W-1:0] res_q;
	logic res_bad_q;

	logic cfg_write;
	logic setup_bad;
	logic take_req;
	logic load_rsp;
	logic scale_last;
	logic mont_last;
	logic exp_last;
	logic [W:0] dbl_raw;
	logic [W:0] dbl_red;
	logic [W-1:0] dbl_val;
	logic [W+1:0] sum1;
	logic [W+1:0] sum2;
	logic [W:0] t_next;
	logic [W:0] mont_red;
	logic [W-1:0] mont_val;
	logic [W-1:0] one_mod_p;

	// config port
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_comb begin
		if (paddr[ADDR_BITS-1] == REG_R_BITS) begin
			prdata = DATA_BITS'(rb_q);
		end else begin
			prdata = DATA_BITS'(p_q);
		end
	end

	// even modulus, or radix not above the modulus
	assign setup_bad = !p_q[0] || ((p_q >> rb_q) != '0);
	assign one_mod_p = (p_q == W'(1)) ? '0 : W'(1);

	assign req_ready = (state_q == S_IDLE);
	assign take_req = req_valid && req_ready;
	assign load_rsp = (state_q == S_OUT) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_data_q;

	assign scale_last = (cnt_q == STEP_W'(W) + STEP_W'(rb_q) - STEP_W'(1));
	assign mont_last = (cnt_q == STEP_W'(rb_q) - STEP_W'(1));
	assign exp_last = (ecnt_q == EXP_W'(1));

	// modular doubling with one dividend bit shifted in
	always_comb begin
		dbl_raw = {v_q, div_shift_q[W-1]};
		if (dbl_raw >= {1'b0, p_q}) begin
			dbl_red = dbl_raw - {1'b0, p_q};
		end else begin
			dbl_red = dbl_raw;
		end
		dbl_val = dbl_red[W-1:0];
	end

	// one radix-2 montgomery step, quotient bit is the parity of the sum
	always_comb begin
		sum1 = {1'b0, t_q} + (ma_q[0] ? {2'b00, mb_q} : '0);
		sum2 = sum1 + (sum1[0] ? {2'b00, p_q} : '0);
		t_next = sum2[W+1:1];
		if (t_next >= {1'b0, p_q}) begin
			mont_red = t_next - {1'b0, p_q};
		end else begin
			mont_red = t_next;
		end
		mont_val = mont_red[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			p_q <= MODULUS_RESET;
			rb_q <= R_BITS_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				if (paddr[ADDR_BITS-1] == REG_MODULUS) begin
					p_q <= pwdata[W-1:0];
				end else begin
					rb_q <= pwdata[RBITS_W-1:0];
				end
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take_req) begin
						state_q <= setup_bad ? S_OUT : S_SCALE_B;
					end
				end
				S_SCALE_B: begin
					if (scale_last) begin
						state_q <= S_SCALE_A;
					end
				end
				S_SCALE_A: begin
					if (scale_last) begin
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					if (mont_last) begin
						if (exp_q[W-1]) begin
							state_q <= S_MUL;
						end else begin
							state_q <= exp_last ? S_FIN : S_SQR;
						end
					end
				end
				S_MUL: begin
					if (mont_last) begin
						state_q <= exp_last ? S_FIN : S_SQR;
					end
				end
				S_FIN: begin
					if (mont_last) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_rsp) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_data_q.result <= res_q;
			rsp_data_q.bad_setup <= res_bad_q;
		end
		case (state_q)
			S_IDLE: begin
				if (take_req) begin
					div_shift_q <= req_data.base;
					exp_q <= req_data.exponent;
					v_q <= '0;
					cnt_q <= '0;
					res_q <= '0;
					res_bad_q <= setup_bad;
				end
			end
			S_SCALE_B: begin
				if (scale_last) begin
					// base*R mod p done, now R mod p from the value one
					base_m_q <= dbl_val;
					div_shift_q <= W'(1);
					v_q <= '0;
					cnt_q <= '0;
				end else begin
					div_shift_q <= div_shift_q << 1;
					v_q <= dbl_val;
					cnt_q <= cnt_q + STEP_W'(1);
				end
			end
			S_SCALE_A: begin
				if (scale_last) begin
					ma_q <= dbl_val;
					mb_q <= dbl_val;
					t_q <= '0;
					cnt_q <= '0;
					ecnt_q <= EXP_W'(W);
				end else begin
					div_shift_q <= div_shift_q << 1;
					v_q <= dbl_val;
					cnt_q <= cnt_q + STEP_W'(1);
				end
			end
			S_SQR, S_MUL, S_FIN: begin
				if (mont_last) begin
					t_q <= '0;
					cnt_q <= '0;
					ma_q <= mont_val;
					if (state_q == S_FIN) begin
						res_q <= mont_val;
					end else if ((state_q == S_SQR) && exp_q[W-1]) begin
						mb_q <= base_m_q;
					end else begin
						// next exponent bit, or leave montgomery form after the last
						exp_q <= exp_q << 1;
						ecnt_q <= ecnt_q - EXP_W'(1);
						mb_q <= exp_last ? one_mod_p : mont_val;
					end
				end else begin
					t_q <= t_next;
					ma_q <= ma_q >> 1;
					cnt_q <= cnt_q + STEP_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	`MME_ASSERT_NEXT(a_bad_setup_short, take_req && setup_bad, state_q == S_OUT,
		"bad setup word did not go straight to the result")
	`MME_ASSERT_IMP(a_scale_bound, (state_q == S_SCALE_B) || (state_q == S_SCALE_A),
		v_q < p_q, "doubler value not reduced below modulus")
	`MME_ASSERT_IMP(a_mont_bound, (state_q == S_SQR) || (state_q == S_MUL) || (state_q == S_FIN),
		(t_q >> 1) < p_q, "montgomery partial sum reached twice the modulus")
	`MME_ASSERT_IMP(a_bad_zero, rsp_valid_q && rsp_data_q.bad_setup,
		rsp_data_q.result == '0, "bad setup word carries a nonzero result")

endmodule
